>>> design/gacsp_pkg.sv
// Types and constants shared by the glyph atlas cache shelf packer.
// No dependencies.
package gacsp_pkg;

  localparam int KEY_W = 23;
  localparam int FIELD_W = 11;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam logic [17:0] CP_LIMIT = 18'h2FFFF;
  localparam logic [11:0] SIZE_MAX_Q = 12'hFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_PROBE,
    ST_PLACE,
    ST_CLEAR,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 has_area;
    logic [FIELD_W-1:0]   x;
    logic [FIELD_W-1:0]   y;
    logic [FIELD_W-1:0]   w;
    logic [FIELD_W-1:0]   h;
  } place_t;

endpackage

>>> design/glyph_atlas_cache_shelf_packer_unit.sv
// Glyph atlas cache: hash table in block memories plus shelf packer.
// Depends on gacsp_pkg.
//
// One request at a time. A request is hashed, its home slot read and probed;
// a hit then goes to the output register, and a miss is first placed, then
// written back. Each extra probe step of the linear-probe walk over the slot
// memory reads the next slot (one read per cycle). A codepoint out of range
// goes straight to the output register. in_ready rises again as the result
// is loaded. After reset, and whenever the atlas fills, a clearing pass writes
// every slot's valid bit to zero, one slot a cycle; after a flush the request
// is probed again, and no request is accepted during the reset pass. The result
// sits in an output register, so the next request is taken and processed while
// it waits; a finished request holds until that register is free.
module glyph_atlas_cache_shelf_packer_unit #(
  parameter int TABLE_ENTRIES = 8192,
  parameter int ATLAS_WIDTH   = 2048,
  parameter int ATLAS_HEIGHT  = 2048,
  parameter int GAP_PIXELS    = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_face_id,
  input  logic [17:0] in_codepoint,
  input  logic [15:0] in_size_fixed,
  input  logic [10:0] in_glyph_width,
  input  logic [10:0] in_glyph_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_valid,
  output logic        out_cache_hit,
  output logic        out_has_area,
  output logic [10:0] out_atlas_x,
  output logic [10:0] out_atlas_y,
  output logic [10:0] out_placed_width,
  output logic [10:0] out_placed_height,
  output logic        out_atlas_cleared
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = 15;
  localparam logic [IW:0] ENTRIES = (IW+1)'(TABLE_ENTRIES);
  localparam logic [CW-1:0] AW = CW'(ATLAS_WIDTH);
  localparam logic [CW-1:0] AH = CW'(ATLAS_HEIGHT);
  localparam logic [CW-1:0] GAP = CW'(GAP_PIXELS);
  localparam int MW = gacsp_pkg::KEY_W + 1 + $bits(gacsp_pkg::place_t);

  // slot memory: {valid, key, placement}
  logic [MW-1:0] mem [TABLE_ENTRIES];
  logic [MW-1:0] rd_q;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  gacsp_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;
  logic [gacsp_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [10:0]   gw_r, gw_nxt, gh_r, gh_nxt;
  logic [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt, sh_r, sh_nxt;
  logic          clr_r, clr_nxt;
  logic          hit_r, hit_nxt;
  logic          rv_r, rv_nxt;
  gacsp_pkg::place_t pl_r, pl_nxt;
  logic          ov_r, ov_nxt;
  logic          o_rv_r, o_rv_nxt, o_hit_r, o_hit_nxt, o_clr_r, o_clr_nxt;
  gacsp_pkg::place_t o_pl_r, o_pl_nxt;

  logic [11:0] size_q;
  logic [12:0] size_sum;
  logic        slot_v;
  logic [gacsp_pkg::KEY_W-1:0] slot_k;
  logic [CW-1:0] rx, ry, rsh;

  assign size_sum = {1'b0, in_size_fixed[15:4]} + 13'(in_size_fixed[3]);
  assign slot_v   = rd_q[MW-1];
  assign slot_k   = rd_q[MW-2 -: gacsp_pkg::KEY_W];

  assign in_ready          = (state_r == gacsp_pkg::ST_IDLE);
  assign out_valid         = ov_r;
  assign out_result_valid  = o_rv_r;
  assign out_cache_hit     = o_hit_r;
  assign out_has_area      = o_pl_r.has_area;
  assign out_atlas_x       = o_pl_r.x;
  assign out_atlas_y       = o_pl_r.y;
  assign out_placed_width  = o_pl_r.w;
  assign out_placed_height = o_pl_r.h;
  assign out_atlas_cleared = o_clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gacsp_pkg::ST_CLEAR;
      cnt_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      sh_r    <= '0;
      ov_r    <= 1'b0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      sh_r    <= sh_nxt;
      ov_r    <= ov_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    key_r   <= key_nxt;
    prod_r  <= prod_nxt;
    gw_r    <= gw_nxt;
    gh_r    <= gh_nxt;
    hit_r   <= hit_nxt;
    rv_r    <= rv_nxt;
    pl_r    <= pl_nxt;
    o_rv_r  <= o_rv_nxt;
    o_hit_r <= o_hit_nxt;
    o_clr_r <= o_clr_nxt;
    o_pl_r  <= o_pl_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    prod_nxt  = prod_r;
    gw_nxt    = gw_r;
    gh_nxt    = gh_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    sh_nxt    = sh_r;
    clr_nxt   = clr_r;
    hit_nxt   = hit_r;
    rv_nxt    = rv_r;
    pl_nxt    = pl_r;
    ov_nxt    = ov_r;
    o_rv_nxt  = o_rv_r;
    o_hit_nxt = o_hit_r;
    o_clr_nxt = o_clr_r;
    o_pl_nxt  = o_pl_r;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = {1'b1, key_r, pl_r};
    size_q    = size_sum[11:0];
    rx        = cx_r;
    ry        = cy_r;
    rsh       = sh_r;
    if (size_sum == 13'd0) begin
      size_q = 12'd1;
    end else if (size_sum[12]) begin
      size_q = gacsp_pkg::SIZE_MAX_Q;
    end

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      gacsp_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          clr_nxt = 1'b0;
          if (in_codepoint > gacsp_pkg::CP_LIMIT) begin
            rv_nxt    = 1'b0;
            hit_nxt   = 1'b0;
            pl_nxt    = '0;
            state_nxt = gacsp_pkg::ST_OUT;
          end else begin
            rv_nxt    = 1'b1;
            key_nxt   = {in_face_id, in_codepoint[8:0], size_q};
            gw_nxt    = in_glyph_width;
            gh_nxt    = in_glyph_height;
            state_nxt = gacsp_pkg::ST_HASH;
          end
        end
      end
      gacsp_pkg::ST_HASH: begin
        prod_nxt  = 32'(32'(key_r) * gacsp_pkg::HASH_MUL);
        state_nxt = gacsp_pkg::ST_READ;
      end
      gacsp_pkg::ST_READ: begin
        idx_nxt   = prod_r[IW-1:0];
        rd_addr   = prod_r[IW-1:0];
        cnt_nxt   = '0;
        state_nxt = gacsp_pkg::ST_PROBE;
      end
      gacsp_pkg::ST_PROBE: begin
        if (!slot_v || slot_k == key_r) begin
          hit_nxt   = slot_v;
          pl_nxt    = rd_q[$bits(gacsp_pkg::place_t)-1:0];
          state_nxt = slot_v ? gacsp_pkg::ST_OUT : gacsp_pkg::ST_PLACE;
        end else if (cnt_r == ENTRIES - 1'b1) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = gacsp_pkg::ST_PLACE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      gacsp_pkg::ST_PLACE: begin
        if (gw_r != '0 && gh_r != '0) begin
          if (!clr_r && cx_r + CW'(gw_r) + GAP > AW) begin
            rx  = '0;
            ry  = cy_r + sh_r + GAP;
            rsh = '0;
          end
          if (!clr_r && ry + CW'(gh_r) + GAP > AH) begin
            cx_nxt    = '0;
            cy_nxt    = '0;
            sh_nxt    = '0;
            clr_nxt   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = gacsp_pkg::ST_CLEAR;
          end else begin
            pl_nxt    = '{1'b1, rx[10:0], ry[10:0], gw_r, gh_r};
            cx_nxt    = rx + CW'(gw_r) + GAP;
            cy_nxt    = ry;
            sh_nxt    = (CW'(gh_r) + GAP > rsh) ? CW'(gh_r) + GAP : rsh;
            state_nxt = gacsp_pkg::ST_WRITE;
          end
        end else begin
          pl_nxt    = '0;
          state_nxt = gacsp_pkg::ST_WRITE;
        end
      end
      gacsp_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[IW-1:0];
        wr_data = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ENTRIES - 1'b1) begin
          state_nxt = clr_r ? gacsp_pkg::ST_READ : gacsp_pkg::ST_IDLE;
        end
      end
      gacsp_pkg::ST_WRITE: begin
        wr_en     = 1'b1;
        state_nxt = gacsp_pkg::ST_OUT;
      end
      gacsp_pkg::ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          o_rv_nxt  = rv_r;
          o_hit_nxt = hit_r;
          o_clr_nxt = clr_r;
          o_pl_nxt  = pl_r;
          state_nxt = gacsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gacsp_pkg::ST_IDLE;
    endcase
  end

  a_hit_not_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cache_hit |-> !out_atlas_cleared)
    else $error("hit reported with atlas clear");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |-> !out_cache_hit && !out_has_area)
    else $error("invalid result carries data");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != gacsp_pkg::ST_IDLE |-> !in_ready)
    else $error("input taken while busy");

endmodule

>>> dv/tb_glyph_atlas_cache_shelf_packer_unit.sv
// Self-checking testbench for the glyph atlas cache shelf packer.
// Predicts hit/miss, shelf placement and atlas flushes in a scoreboard class.
// Depends on gacsp_pkg and glyph_atlas_cache_shelf_packer_unit.
module tb_glyph_atlas_cache_shelf_packer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 8192;
  localparam int AW = 2048;
  localparam int AH = 2048;
  localparam int GAP = 1;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic rv;
    logic hit;
    logic area;
    logic [10:0] x;
    logic [10:0] y;
    logic [10:0] w;
    logic [10:0] h;
    logic clr;
  } glyph_res_t;

  class atlas_scoreboard;
    logic [22:0] key_mem[ENTRIES];
    bit valid_mem[ENTRIES];
    gacsp_pkg::place_t place_mem[ENTRIES];
    int unsigned cur_x, cur_y, shelf_h;
    glyph_res_t pending[$];
    int errors;
    int n_hits;
    int n_clears;
    int n_invalid;
    int n_results;

    function new();
      foreach (valid_mem[i]) valid_mem[i] = 0;
      cur_x = 0;
      cur_y = 0;
      shelf_h = 0;
      errors = 0;
      n_hits = 0;
      n_clears = 0;
      n_invalid = 0;
      n_results = 0;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    function int unsigned probe(logic [22:0] key);
      logic [31:0] prod;
      int unsigned i;
      prod = {9'd0, key} * gacsp_pkg::HASH_MUL;
      i = prod % ENTRIES;
      for (int n = 0; n < ENTRIES; n++) begin
        if (!valid_mem[i] || key_mem[i] == key) return i;
        i = (i + 1) % ENTRIES;
      end
      return 0;
    endfunction

    function void note_request(logic [1:0] face, logic [17:0] cp, logic [15:0] sz,
                               logic [10:0] gw, logic [10:0] gh);
      glyph_res_t r;
      int unsigned sq, slot;
      logic [22:0] key;
      gacsp_pkg::place_t p;
      r = '0;
      if (cp > gacsp_pkg::CP_LIMIT) begin
        pending.push_back(r);
        return;
      end
      sq = (int'(sz) + 8) >> 4;
      if (sq < 1) sq = 1;
      if (sq > gacsp_pkg::SIZE_MAX_Q) sq = gacsp_pkg::SIZE_MAX_Q;
      key = {face, cp[8:0], sq[11:0]};
      slot = probe(key);
      r.rv = 1;
      if (valid_mem[slot] && key_mem[slot] == key) begin
        p = place_mem[slot];
        r.hit = 1;
      end else begin
        p = '0;
        if (gw != 0 && gh != 0) begin
          if (cur_x + gw + GAP > AW) begin
            cur_x = 0;
            cur_y += shelf_h + GAP;
            shelf_h = 0;
          end
          if (cur_y + gh + GAP > AH) begin
            foreach (valid_mem[i]) valid_mem[i] = 0;
            cur_x = 0;
            cur_y = 0;
            shelf_h = 0;
            r.clr = 1;
            slot = probe(key);
          end
          p.has_area = 1;
          p.x = cur_x[10:0];
          p.y = cur_y[10:0];
          p.w = gw;
          p.h = gh;
          cur_x += gw + GAP;
          if (gh + GAP > shelf_h) shelf_h = gh + GAP;
        end
        key_mem[slot] = key;
        valid_mem[slot] = 1;
        place_mem[slot] = p;
      end
      r.area = p.has_area;
      r.x = p.x;
      r.y = p.y;
      r.w = p.w;
      r.h = p.h;
      pending.push_back(r);
    endfunction

    task check_result(glyph_res_t g);
      glyph_res_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 0, 0);
        return;
      end
      e = pending.pop_front();
      n_results++;
      if (e.hit) n_hits++;
      if (e.clr) n_clears++;
      if (!e.rv) n_invalid++;
      if (g.rv !== e.rv) report("result_valid", g.rv, e.rv);
      if (g.hit !== e.hit) report("cache_hit", g.hit, e.hit);
      if (g.area !== e.area) report("has_area", g.area, e.area);
      if (g.x !== e.x) report("atlas_x", g.x, e.x);
      if (g.y !== e.y) report("atlas_y", g.y, e.y);
      if (g.w !== e.w) report("placed_width", g.w, e.w);
      if (g.h !== e.h) report("placed_height", g.h, e.h);
      if (g.clr !== e.clr) report("atlas_cleared", g.clr, e.clr);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_face_id = 0;
  logic [17:0] in_codepoint = 0;
  logic [15:0] in_size_fixed = 0;
  logic [10:0] in_glyph_width = 0;
  logic [10:0] in_glyph_height = 0;
  logic out_valid;
  logic out_ready = 0;
  logic out_result_valid, out_cache_hit, out_has_area, out_atlas_cleared;
  logic [10:0] out_atlas_x, out_atlas_y, out_placed_width, out_placed_height;

  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  longint cycles = 0;
  atlas_scoreboard sb = new();

  always #5 clk = ~clk;

  glyph_atlas_cache_shelf_packer_unit uut (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_face_id, in_codepoint, in_size_fixed,
                      in_glyph_width, in_glyph_height);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_result_valid, out_cache_hit, out_has_area, out_atlas_x,
                       out_atlas_y, out_placed_width, out_placed_height,
                       out_atlas_cleared});
  end

  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send(input logic [1:0] f, input logic [17:0] cp, input logic [15:0] sz,
                      input logic [10:0] w, input logic [10:0] h);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_face_id <= f;
    in_codepoint <= cp;
    in_size_fixed <= sz;
    in_glyph_width <= w;
    in_glyph_height <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [17:0] cp;
    logic [10:0] w, h;
    int sel;
    sel = $urandom_range(99);
    cp = (sel < 8) ? 18'($urandom_range(262143, 196608)) : 18'($urandom_range(196607));
    if (sel < 50) cp = 18'($urandom_range(31));
    if ($urandom_range(9) == 0) begin
      w = 11'($urandom);
      h = 11'($urandom);
    end else begin
      w = 11'($urandom_range(64));
      h = 11'($urandom_range(64));
    end
    if ($urandom_range(19) == 0) w = 0;
    send(2'($urandom), cp, (sel < 50) ? 16'($urandom_range(3) * 16) : 16'($urandom), w, h);
  endtask

  initial begin
    int phase_idle[4] = '{0, 72, 0, 30};
    int phase_stall[4] = '{0, 0, 72, 30};
    int waited;
    repeat (8) @(negedge clk);
    rst_n <= 1;

    send(0, 18'h00041, 16'd256, 11'd10, 11'd12);
    send(0, 18'h00041, 16'd256, 11'd99, 11'd99);
    send(0, 18'h00241, 16'd256, 11'd5, 11'd5);
    send(3, 18'h2FFFF, 16'hFFFF, 11'd2047, 11'd1);
    send(3, 18'h30000, 16'hFFFF, 11'd7, 11'd7);
    send(3, 18'h3FFFF, 16'h0000, 11'h7FF, 11'h7FF);
    send(1, 18'h00000, 16'd0, 11'd0, 11'd20);
    send(1, 18'h00000, 16'd7, 11'd3, 11'd3);
    send(1, 18'h00000, 16'd8, 11'd4, 11'd4);
    send(2, 18'h00010, 16'd300, 11'd30, 11'd0);
    send(2, 18'h00011, 16'd300, 11'd1500, 11'd40);
    send(2, 18'h00012, 16'd300, 11'd1500, 11'd40);
    send(2, 18'h00013, 16'd300, 11'd2047, 11'd2047);
    send(2, 18'h00014, 16'd300, 11'd2047, 11'd2047);
    send(2, 18'h00013, 16'd300, 11'd1, 11'd1);
    send(0, 18'h1FFFF, 16'hFFF7, 11'd1, 11'd1);
    send(0, 18'h2AAAA, 16'h5555, 11'h555, 11'h2AA);

    hold_off = 1;
    fork
      repeat (40) send_random();
      begin repeat (400) @(posedge clk); end
    join_any
    hold_off = 0;
    wait fork;

    for (int p = 0; p < 4; p++) begin
      send_idle = phase_idle[p];
      recv_stall = phase_stall[p];
      repeat (170) send_random();
    end
    in_valid <= 0;
    send_idle = 0;
    recv_stall = 0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("results outstanding", sb.pending.size(), 0);
    $display("covered %0d results: %0d hits, %0d invalid codepoints, %0d atlas flushes",
             sb.n_results, sb.n_hits, sb.n_invalid, sb.n_clears);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
